@@ hw/rtl/map_pkg.sv @@
// Shared widths, register indexes, mode codes and saturation helper for the attitude controller.
// Used by the shared multiplier and the top level; depends on nothing.
package map_pkg;

   localparam int MUL_A_W = 18;
   localparam int MUL_B_W = 10;
   localparam int MUL_P_W = 28;

   localparam logic [2:0] REG_ROLL_GAINS  = 3'd0;
   localparam logic [2:0] REG_PITCH_GAINS = 3'd1;
   localparam logic [2:0] REG_YAW_GAINS   = 3'd2;
   localparam logic [2:0] REG_LEVEL_GAINS = 3'd3;
   localparam logic [2:0] REG_YAW_RATE    = 3'd4;
   localparam logic [2:0] REG_TRIM_ROLL   = 3'd5;
   localparam logic [2:0] REG_TRIM_PITCH  = 3'd6;

   localparam logic [1:0] MODE_ANGLE   = 2'd1;
   localparam logic [1:0] MODE_HORIZON = 2'd2;

   function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
      logic signed [15:0] r;
      if (v > 22'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -22'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/multirotor_attitude_pid.sv @@
// Top level of the multirotor attitude controller: sequencer, state and registers.
// Depends on map_pkg and on the shared multiplier map_mul.
//
// Each item on the req_ channel is one control cycle: stick commands, gyro rates,
// estimated angles, level mode, an integrator clear flag and throttle scale factors.
// The rsp_ channel returns one item with the roll, pitch and yaw drive values.
// The user must write gains, yaw rate and trims through the csr_ port only
// while the block is idle; the block itself does not enforce it. All products go
// through one multiplier, one product per cycle, under a sequencer that steps
// through the roll axis, the pitch axis and then yaw before loading the result
// register. req_tready is high only while the sequencer is idle, so a new item
// is not taken until the last one has been loaded into the result register.
// A result waits in the output register until it is taken. If the previous result
// is still waiting when the next one is done, the sequencer holds its last step.
// A synchronous reset clears the configuration registers, the integrators and
// the gyro history and leaves the block idle with no result pending.
module multirotor_attitude_pid (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // rc_roll, rc_pitch, rc_yaw, gyro_roll, gyro_pitch, gyro_yaw, angle_roll,
   // angle_pitch, level_mode, clear_integrators, scale_roll, scale_pitch, 5 pad bits
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // drive_roll, drive_pitch, drive_yaw
   output logic [47:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [23:0]  csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_AXIS = 2'd1;
   localparam logic [1:0] ST_YAW  = 2'd2;

   localparam logic [3:0] STEP_RATE_I  = 4'd0;
   localparam logic [3:0] STEP_DYN_D   = 4'd1;
   localparam logic [3:0] STEP_I_TERM  = 4'd2;
   localparam logic [3:0] STEP_P_TERM  = 4'd3;
   localparam logic [3:0] STEP_LVL_P   = 4'd4;
   localparam logic [3:0] STEP_LVL_I   = 4'd5;
   localparam logic [3:0] STEP_BLEND_I = 4'd6;
   localparam logic [3:0] STEP_BLEND_P = 4'd7;
   localparam logic [3:0] STEP_DAMP    = 4'd8;
   localparam logic [3:0] STEP_D_TERM  = 4'd9;

   localparam logic [3:0] STEP_YAW_CMD = 4'd0;
   localparam logic [3:0] STEP_YAW_I   = 4'd1;
   localparam logic [3:0] STEP_YAW_P   = 4'd2;
   localparam logic [3:0] STEP_YAW_OUT = 4'd3;

   // Configuration registers.
   logic [23:0]        roll_gains_ff, pitch_gains_ff, yaw_gains_ff, level_gains_ff;
   logic [7:0]         yaw_rate_ff;
   logic signed [9:0]  trim_ff [2];

   // Sequencer.
   logic [1:0] st_ff, st_in;
   logic [3:0] step_ff, step_in;
   logic       axis_ff, axis_in;

   // Latched item fields.
   logic signed [9:0]  rc_ff [3];
   logic signed [9:0]  rc_in [3];
   logic signed [13:0] gyro_ff [3];
   logic signed [13:0] gyro_in [3];
   logic signed [11:0] ang_ff [2];
   logic signed [11:0] ang_in [2];
   logic [7:0]         scale_ff [2];
   logic [7:0]         scale_in [2];
   logic [1:0]         mode_ff, mode_in;
   logic [9:0]         prop_ff, prop_in;

   // Working registers.
   logic [8:0]          dynp_ff, dynp_in, dynd_ff, dynd_in;
   logic signed [17:0]  it_ff, it_in, pt_ff, pt_in, dsum_ff, dsum_in;
   logic signed [11:0]  pacc_ff, pacc_in, iacc_ff, iacc_in;
   logic signed [15:0]  drv_ff [2];
   logic signed [15:0]  drv_in [2];
   logic signed [14:0]  yrc_ff, yrc_in;
   logic signed [9:0]   ypt_ff, ypt_in;

   // Controller state.
   logic signed [14:0]  ri_ff [2];
   logic signed [14:0]  ri_in [2];
   logic signed [14:0]  li_ff [2];
   logic signed [14:0]  li_in [2];
   logic signed [29:0]  yint_ff, yint_in;
   logic signed [13:0]  prev_ff [2];
   logic signed [13:0]  prev_in [2];
   logic signed [14:0]  d1_ff [2];
   logic signed [14:0]  d1_in [2];
   logic signed [14:0]  d2_ff [2];
   logic signed [14:0]  d2_in [2];

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;

   // Shared multiplier.
   logic signed [map_pkg::MUL_A_W-1:0] mul_a;
   logic        [map_pkg::MUL_B_W-1:0] mul_b;
   logic signed [map_pkg::MUL_P_W-1:0] prod;

   map_mul u_mul (
      .a (mul_a),
      .b (mul_b),
      .p (prod)
   );

   // Per-axis views.
   logic [23:0]        gains;
   logic [7:0]         p8, i8, d8, lp, li, ld, yp, yi, yd;
   logic signed [9:0]  rcm;
   logic signed [10:0] rc2, rc_cl;
   logic signed [13:0] gy;
   logic signed [15:0] err;
   logic signed [16:0] ri_sum;
   logic signed [14:0] ri_new;
   logic signed [13:0] ea;
   logic signed [15:0] li_sum;
   logic signed [14:0] li_new;
   logic signed [14:0] delta;
   logic               lvl_on;
   logic [10:0]        ld5;
   logic signed [27:0] lvl_p_raw;
   logic signed [21:0] axis_sum;
   logic signed [16:0] erry;
   logic signed [30:0] ysum;
   logic signed [27:0] yp_raw;
   logic [9:0]         ylim;
   logic signed [16:0] yit_raw;
   logic signed [8:0]  yit;
   logic signed [15:0] yout;
   logic signed [10:0] abs_r, abs_p, abs_max;
   logic signed [9:0]  req_rc_roll, req_rc_pitch;

   assign gains  = axis_ff ? pitch_gains_ff : roll_gains_ff;
   assign p8     = gains[7:0];
   assign i8     = gains[15:8];
   assign d8     = gains[23:16];
   assign lp     = level_gains_ff[7:0];
   assign li     = level_gains_ff[15:8];
   assign ld     = level_gains_ff[23:16];
   assign yp     = yaw_gains_ff[7:0];
   assign yi     = yaw_gains_ff[15:8];
   assign yd     = yaw_gains_ff[23:16];
   assign lvl_on = (mode_ff == map_pkg::MODE_ANGLE) || (mode_ff == map_pkg::MODE_HORIZON);
   assign ld5    = 11'({ld, 2'b00}) + 11'(ld);

   assign rcm    = rc_ff[axis_ff];
   assign rc2    = {rcm, 1'b0};
   assign gy     = gyro_ff[axis_ff];
   assign err    = 16'(rc2) - 16'(gy);
   assign ri_sum = 17'(ri_ff[axis_ff]) + 17'(err);
   assign ri_new = (gy > 14'sd640 || gy < -14'sd640) ? 15'sd0 :
                   (ri_sum > 17'sd16000) ? 15'sd16000 :
                   (ri_sum < -17'sd16000) ? -15'sd16000 : 15'(ri_sum);
   assign rc_cl  = (rc2 > 11'sd500) ? 11'sd500 : (rc2 < -11'sd500) ? -11'sd500 : rc2;
   assign ea     = 14'(rc_cl) - 14'(ang_ff[axis_ff]) + 14'(trim_ff[axis_ff]);
   assign li_sum = 16'(li_ff[axis_ff]) + 16'(ea);
   assign li_new = (li_sum > 16'sd10000) ? 15'sd10000 :
                   (li_sum < -16'sd10000) ? -15'sd10000 : 15'(li_sum);
   assign delta  = 15'(gy) - 15'(prev_ff[axis_ff]);

   assign lvl_p_raw = prod >>> 7;
   assign axis_sum  = 22'(pt_ff) + 22'(it_ff) - 22'(prod >>> 5);

   assign erry    = 17'(yrc_ff) - 17'(gyro_ff[2]);
   assign ysum    = 31'(yint_ff) + 31'(prod);
   assign yp_raw  = prod >>> 6;
   assign ylim    = 10'd300 - 10'(yd);
   assign yit_raw = 17'(yint_ff >>> 13);
   assign yit     = (yit_raw > 17'sd250) ? 9'sd250 :
                    (yit_raw < -17'sd250) ? -9'sd250 : 9'(yit_raw);
   assign yout    = 16'(ypt_ff) + 16'(yit);

   assign req_rc_roll  = $signed(req_tdata[9:0]);
   assign req_rc_pitch = $signed(req_tdata[19:10]);
   assign abs_r   = (req_rc_roll < 0) ? -11'(req_rc_roll) : 11'(req_rc_roll);
   assign abs_p   = (req_rc_pitch < 0) ? -11'(req_rc_pitch) : 11'(req_rc_pitch);
   assign abs_max = (abs_r > abs_p) ? abs_r : abs_p;

   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (st_ff == ST_YAW) begin
         unique case (step_ff)
            STEP_YAW_CMD: begin
               mul_a = 18'(rc_ff[2]);
               mul_b = 10'({yaw_rate_ff, 1'b0}) + 10'd30;
            end
            STEP_YAW_I: begin
               mul_a = 18'(erry);
               mul_b = 10'(yi);
            end
            STEP_YAW_P: begin
               mul_a = 18'(erry);
               mul_b = 10'(yp);
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end else begin
         unique case (step_ff)
            STEP_RATE_I: begin
               mul_a = 18'(scale_ff[axis_ff]);
               mul_b = 10'(p8);
            end
            STEP_DYN_D: begin
               mul_a = 18'(scale_ff[axis_ff]);
               mul_b = 10'(d8);
            end
            STEP_I_TERM: begin
               mul_a = 18'(ri_ff[axis_ff] >>> 7);
               mul_b = 10'(i8);
            end
            STEP_P_TERM: begin
               mul_a = 18'(rc2);
               mul_b = 10'(p8);
            end
            STEP_LVL_P: begin
               mul_a = 18'(ea);
               mul_b = 10'(lp);
            end
            STEP_LVL_I: begin
               mul_a = 18'(li_ff[axis_ff]);
               mul_b = 10'(li);
            end
            STEP_BLEND_I: begin
               mul_a = it_ff - 18'(iacc_ff);
               mul_b = prop_ff;
            end
            STEP_BLEND_P: begin
               mul_a = pt_ff - 18'(pacc_ff);
               mul_b = prop_ff;
            end
            STEP_DAMP: begin
               mul_a = 18'(gy);
               mul_b = 10'(dynp_ff);
            end
            STEP_D_TERM: begin
               mul_a = dsum_ff;
               mul_b = 10'(dynd_ff);
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   always_comb begin
      st_in        = st_ff;
      step_in      = step_ff;
      axis_in      = axis_ff;
      rc_in        = rc_ff;
      gyro_in      = gyro_ff;
      ang_in       = ang_ff;
      scale_in     = scale_ff;
      mode_in      = mode_ff;
      prop_in      = prop_ff;
      dynp_in      = dynp_ff;
      dynd_in      = dynd_ff;
      it_in        = it_ff;
      pt_in        = pt_ff;
      dsum_in      = dsum_ff;
      pacc_in      = pacc_ff;
      iacc_in      = iacc_ff;
      drv_in       = drv_ff;
      yrc_in       = yrc_ff;
      ypt_in       = ypt_ff;
      ri_in        = ri_ff;
      li_in        = li_ff;
      yint_in      = yint_ff;
      prev_in      = prev_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (st_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rc_in[0]    = $signed(req_tdata[9:0]);
               rc_in[1]    = $signed(req_tdata[19:10]);
               rc_in[2]    = $signed(req_tdata[29:20]);
               gyro_in[0]  = $signed(req_tdata[43:30]);
               gyro_in[1]  = $signed(req_tdata[57:44]);
               gyro_in[2]  = $signed(req_tdata[71:58]);
               ang_in[0]   = $signed(req_tdata[83:72]);
               ang_in[1]   = $signed(req_tdata[95:84]);
               mode_in     = req_tdata[97:96];
               scale_in[0] = req_tdata[106:99];
               scale_in[1] = req_tdata[114:107];
               if (req_tdata[97:96] == map_pkg::MODE_HORIZON) begin
                  prop_in = (abs_max > 11'sd512) ? 10'd512 : 10'(abs_max);
               end else begin
                  prop_in = '0;
               end
               if (req_tdata[98]) begin
                  ri_in[0] = '0;
                  ri_in[1] = '0;
                  li_in[0] = '0;
                  li_in[1] = '0;
                  yint_in  = '0;
               end
               st_in   = ST_AXIS;
               step_in = STEP_RATE_I;
               axis_in = 1'b0;
            end
         end
         ST_AXIS: begin
            step_in = step_ff + 4'd1;
            unique case (step_ff)
               STEP_RATE_I: begin
                  dynp_in          = prod[15:7];
                  ri_in[axis_ff]   = ri_new;
                  if (lvl_on) begin
                     li_in[axis_ff] = li_new;
                  end
                  prev_in[axis_ff] = gy;
                  d1_in[axis_ff]   = delta;
                  d2_in[axis_ff]   = d1_ff[axis_ff];
                  dsum_in          = 18'(d1_ff[axis_ff]) + 18'(d2_ff[axis_ff]) + 18'(delta);
               end
               STEP_DYN_D: begin
                  dynd_in = prod[15:7];
               end
               STEP_I_TERM: begin
                  it_in = 18'(prod >>> 6);
               end
               STEP_P_TERM: begin
                  pt_in = 18'(prod >>> 6);
               end
               STEP_LVL_P: begin
                  if (lvl_p_raw > $signed(28'(ld5))) begin
                     pacc_in = 12'(ld5);
                  end else if (lvl_p_raw < -$signed(28'(ld5))) begin
                     pacc_in = -12'(ld5);
                  end else begin
                     pacc_in = 12'(lvl_p_raw);
                  end
               end
               STEP_LVL_I: begin
                  iacc_in = 12'(prod >>> 12);
               end
               STEP_BLEND_I: begin
                  if (lvl_on) begin
                     it_in = 18'(iacc_ff) + 18'(prod >>> 9);
                  end
               end
               STEP_BLEND_P: begin
                  if (lvl_on) begin
                     pt_in = 18'(pacc_ff) + 18'(prod >>> 9);
                  end
               end
               STEP_DAMP: begin
                  pt_in = pt_ff - 18'(prod >>> 6);
               end
               STEP_D_TERM: begin
                  drv_in[axis_ff] = map_pkg::sat16(axis_sum);
                  step_in         = STEP_RATE_I;
                  if (axis_ff) begin
                     st_in   = ST_YAW;
                     step_in = STEP_YAW_CMD;
                  end else begin
                     axis_in = 1'b1;
                  end
               end
               default: begin
                  st_in = ST_IDLE;
               end
            endcase
         end
         ST_YAW: begin
            step_in = step_ff + 4'd1;
            unique case (step_ff)
               STEP_YAW_CMD: begin
                  yrc_in = 15'(prod >>> 5);
               end
               STEP_YAW_I: begin
                  if (yrc_ff > 15'sd50 || yrc_ff < -15'sd50) begin
                     yint_in = '0;
                  end else if (ysum > 31'sd268435454) begin
                     yint_in = 30'sd268435454;
                  end else if (ysum < -31'sd268435454) begin
                     yint_in = -30'sd268435454;
                  end else begin
                     yint_in = 30'(ysum);
                  end
               end
               STEP_YAW_P: begin
                  if (yp_raw > $signed(28'(ylim))) begin
                     ypt_in = 10'(ylim);
                  end else if (yp_raw < -$signed(28'(ylim))) begin
                     ypt_in = -10'(ylim);
                  end else begin
                     ypt_in = 10'(yp_raw);
                  end
               end
               STEP_YAW_OUT: begin
                  if (!rsp_valid_ff || rsp_tready) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = {yout, drv_ff[1], drv_ff[0]};
                     st_in        = ST_IDLE;
                     step_in      = STEP_RATE_I;
                  end else begin
                     step_in = step_ff;
                  end
               end
               default: begin
                  st_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_gains_ff  <= '0;
         pitch_gains_ff <= '0;
         yaw_gains_ff   <= '0;
         level_gains_ff <= '0;
         yaw_rate_ff    <= '0;
         trim_ff[0]     <= '0;
         trim_ff[1]     <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            map_pkg::REG_ROLL_GAINS:  roll_gains_ff  <= csr_wdata;
            map_pkg::REG_PITCH_GAINS: pitch_gains_ff <= csr_wdata;
            map_pkg::REG_YAW_GAINS:   yaw_gains_ff   <= csr_wdata;
            map_pkg::REG_LEVEL_GAINS: level_gains_ff <= csr_wdata;
            map_pkg::REG_YAW_RATE:    yaw_rate_ff    <= csr_wdata[7:0];
            map_pkg::REG_TRIM_ROLL:   trim_ff[0]     <= $signed(csr_wdata[9:0]);
            map_pkg::REG_TRIM_PITCH:  trim_ff[1]     <= $signed(csr_wdata[9:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         step_ff      <= STEP_RATE_I;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ri_ff[0]     <= '0;
         ri_ff[1]     <= '0;
         li_ff[0]     <= '0;
         li_ff[1]     <= '0;
         yint_ff      <= '0;
         prev_ff[0]   <= '0;
         prev_ff[1]   <= '0;
         d1_ff[0]     <= '0;
         d1_ff[1]     <= '0;
         d2_ff[0]     <= '0;
         d2_ff[1]     <= '0;
      end else begin
         st_ff        <= st_in;
         step_ff      <= step_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         ri_ff        <= ri_in;
         li_ff        <= li_in;
         yint_ff      <= yint_in;
         prev_ff      <= prev_in;
         d1_ff        <= d1_in;
         d2_ff        <= d2_in;
      end
   end

   always_ff @(posedge clock) begin
      rc_ff       <= rc_in;
      gyro_ff     <= gyro_in;
      ang_ff      <= ang_in;
      scale_ff    <= scale_in;
      mode_ff     <= mode_in;
      prop_ff     <= prop_in;
      dynp_ff     <= dynp_in;
      dynd_ff     <= dynd_in;
      it_ff       <= it_in;
      pt_ff       <= pt_in;
      dsum_ff     <= dsum_in;
      pacc_ff     <= pacc_in;
      iacc_ff     <= iacc_in;
      drv_ff      <= drv_in;
      yrc_ff      <= yrc_in;
      ypt_ff      <= ypt_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ hw/rtl/map_mul.sv @@
// Shared signed by unsigned multiplier of the attitude controller.
// Depends on map_pkg for its operand widths.
module map_mul (
   input  logic signed [map_pkg::MUL_A_W-1:0] a,
   input  logic        [map_pkg::MUL_B_W-1:0] b,
   output logic signed [map_pkg::MUL_P_W-1:0] p
);

   logic signed [map_pkg::MUL_P_W-1:0] a_ext;
   logic signed [map_pkg::MUL_P_W-1:0] b_ext;

   assign a_ext = map_pkg::MUL_P_W'(a);
   assign b_ext = $signed(map_pkg::MUL_P_W'(b));
   assign p     = a_ext * b_ext;

endmodule
